[rtl/core/tcm_pkg.sv]
package tcm_pkg;

	// Command codes carried on the cmd port.
	typedef enum logic [1:0] {
		CMD_PUT_CHAR   = 2'd0,
		CMD_BACKSPACE  = 2'd1,
		CMD_MOUSE_MOVE = 2'd2,
		CMD_READ_CELL  = 2'd3
	} cmd_t;

	// Character and attribute values used by the console.
	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [7:0] SPACE_CHAR   = 8'h20;
	localparam logic [7:0] ATTR_BLANK   = 8'h07;
	localparam logic [7:0] ATTR_MOUSE   = 8'h70;

	// Write controls for the attribute and character memories.
	typedef struct packed {
		logic       attr_we;
		logic       char_we;
		logic [7:0] attr;
		logic [7:0] chr;
	} mem_wr_t;

endpackage

[rtl/core/tcm_cells.sv]
// Screen store: one attribute memory and one character memory, each with
// one write port and one registered read port on a shared read address.
module tcm_cells #(
	parameter int DEPTH = 2000,
	parameter int AW = 11
) (
	input  logic             clk,
	input  tcm_pkg::mem_wr_t wr,
	input  logic [AW-1:0]    waddr,
	input  logic [AW-1:0]    raddr,
	output logic [7:0]       attr_rdata,
	output logic [7:0]       char_rdata
);

	logic [7:0] attr_mem [DEPTH];
	logic [7:0] char_mem [DEPTH];

	// Attribute bytes.
	always_ff @(posedge clk) begin
		if (wr.attr_we) begin
			attr_mem[waddr] <= wr.attr;
		end
		attr_rdata <= attr_mem[raddr];
	end

	// Character bytes.
	always_ff @(posedge clk) begin
		if (wr.char_we) begin
			char_mem[waddr] <= wr.chr;
		end
		char_rdata <= char_mem[raddr];
	end

endmodule

[rtl/core/text_console_with_mouse_cursor.sv]
// put_char, backspace and read_cell: done is raised as the block leaves S_EXEC for
// S_IDLE, and the next command is taken in that same cycle.
// mouse_move: S_EXEC, S_MOUSE_RD and S_MOUSE_WR, or S_EXEC alone when the position does
// not change; the two attribute read-modify-writes share one read port. A put_char that
// runs past the last row sweeps the characters one cell per cycle in S_CLEAR. The receiver
// cannot stall done. After reset busy stays high while S_INIT writes every cell.
module text_console_with_mouse_cursor #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cmd,
	input  logic [7:0]         char_code,
	input  logic signed [7:0]  move_dx,
	input  logic signed [7:0]  move_dy,
	input  logic [10:0]        cell_index,
	output logic               done,
	output logic [15:0]        cell_data,
	output logic [6:0]         cursor_col,
	output logic [4:0]         cursor_row,
	output logic [6:0]         mouse_col,
	output logic [4:0]         mouse_row
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int AW = $clog2(CELL_COUNT);
	localparam int HOME_COL = COLUMNS / 2;
	localparam int HOME_ROW = ROWS / 2;
	localparam int HOME_ADDR = HOME_ROW * COLUMNS + HOME_COL;
	localparam int LAST_ADDR = CELL_COUNT - 1;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_MOUSE_RD,
		S_MOUSE_WR,
		S_CLEAR
	} state_t;

	state_t              state_q;
	tcm_pkg::cmd_t       cmd_q;
	logic [7:0]          char_q;
	logic signed [7:0]   dx_q;
	logic signed [7:0]   dy_q;
	logic                idx_ok_q;
	logic [AW-1:0]       sweep_q;
	logic [6:0]          write_col_q;
	logic [4:0]          write_row_q;
	logic [6:0]          ptr_col_q;
	logic [4:0]          ptr_row_q;
	logic                done_q;
	logic [15:0]         cell_data_q;

	logic [AW-1:0]       cur_addr;
	logic [AW-1:0]       ptr_addr;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       wr_addr;
	tcm_pkg::mem_wr_t    wr;
	logic [7:0]          attr_rdata;
	logic [7:0]          char_rdata;

	logic [7:0]          col_inc;
	logic [5:0]          row_inc;
	logic [7:0]          next_col;
	logic [5:0]          next_row;
	logic                screen_full;
	logic signed [9:0]   col_sum;
	logic signed [9:0]   row_dif;
	logic [6:0]          new_ptr_col;
	logic [4:0]          new_ptr_row;
	logic                ptr_moved;
	logic                accept;

	assign accept = start && (state_q == S_IDLE);

	// Cell addresses of the write cursor and the mouse cursor.
	assign cur_addr = AW'(32'(write_row_q) * COLUMNS + 32'(write_col_q));
	assign ptr_addr = AW'(32'(ptr_row_q) * COLUMNS + 32'(ptr_col_q));

	// Write cursor advance for put_char.
	always_comb begin
		col_inc = {1'b0, write_col_q} + 8'd1;
		row_inc = {1'b0, write_row_q} + 6'd1;
		if (char_q == tcm_pkg::NEWLINE_CHAR || 32'(col_inc) >= COLUMNS) begin
			next_col = 8'd0;
			next_row = row_inc;
		end else begin
			next_col = col_inc;
			next_row = {1'b0, write_row_q};
		end
		screen_full = 32'(next_row) >= ROWS;
	end

	// Mouse move with signed clamping to the screen.
	always_comb begin
		col_sum = $signed({3'b000, ptr_col_q}) + $signed({{2{dx_q[7]}}, dx_q});
		row_dif = $signed({5'b00000, ptr_row_q}) - $signed({{2{dy_q[7]}}, dy_q});
		if (col_sum < 10'sd0) begin
			new_ptr_col = 7'd0;
		end else if (col_sum > $signed(10'(COLUMNS - 1))) begin
			new_ptr_col = 7'(COLUMNS - 1);
		end else begin
			new_ptr_col = 7'(col_sum);
		end
		if (row_dif < 10'sd0) begin
			new_ptr_row = 5'd0;
		end else if (row_dif > $signed(10'(ROWS - 1))) begin
			new_ptr_row = 5'(ROWS - 1);
		end else begin
			new_ptr_row = 5'(row_dif);
		end
		ptr_moved = (new_ptr_col != ptr_col_q) || (new_ptr_row != ptr_row_q);
	end

	// Read address: the requested cell when a read is accepted, otherwise the
	// mouse cell, so the old attribute is ready in the cycle after the accept.
	assign rd_addr = (accept && tcm_pkg::cmd_t'(cmd) == tcm_pkg::CMD_READ_CELL)
		? AW'(cell_index) : ptr_addr;

	// Memory writes for each state.
	always_comb begin
		wr.attr_we = 1'b0;
		wr.char_we = 1'b0;
		wr.attr = {attr_rdata[3:0], attr_rdata[7:4]};
		wr.chr = tcm_pkg::SPACE_CHAR;
		wr_addr = ptr_addr;
		case (state_q)
			S_INIT: begin
				wr.attr_we = 1'b1;
				wr.char_we = 1'b1;
				wr_addr = sweep_q;
				wr.attr = (sweep_q == AW'(HOME_ADDR)) ? tcm_pkg::ATTR_MOUSE
					: tcm_pkg::ATTR_BLANK;
			end
			S_EXEC: begin
				case (cmd_q)
					tcm_pkg::CMD_PUT_CHAR: begin
						wr.char_we = (char_q != tcm_pkg::NEWLINE_CHAR);
						wr_addr = cur_addr;
						wr.chr = char_q;
					end
					tcm_pkg::CMD_BACKSPACE: begin
						wr.char_we = (write_col_q != 7'd0);
						wr_addr = cur_addr - AW'(1);
					end
					tcm_pkg::CMD_MOUSE_MOVE: begin
						wr.attr_we = ptr_moved;
					end
					default: begin
					end
				endcase
			end
			S_MOUSE_WR: begin
				wr.attr_we = 1'b1;
			end
			S_CLEAR: begin
				wr.char_we = 1'b1;
				wr_addr = sweep_q;
			end
			default: begin
			end
		endcase
	end

	tcm_cells #(
		.DEPTH(CELL_COUNT),
		.AW(AW)
	) u_cells (
		.clk(clk),
		.wr(wr),
		.waddr(wr_addr),
		.raddr(rd_addr),
		.attr_rdata(attr_rdata),
		.char_rdata(char_rdata)
	);

	// Command sequencer, cursors and the registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cmd_q <= tcm_pkg::CMD_PUT_CHAR;
			char_q <= 8'd0;
			dx_q <= 8'sd0;
			dy_q <= 8'sd0;
			idx_ok_q <= 1'b0;
			sweep_q <= '0;
			write_col_q <= 7'd0;
			write_row_q <= 5'd0;
			ptr_col_q <= 7'(HOME_COL);
			ptr_row_q <= 5'(HOME_ROW);
			done_q <= 1'b0;
			cell_data_q <= 16'd0;
		end else begin
			case (state_q)
				S_INIT: begin
					done_q <= 1'b0;
					if (sweep_q == AW'(LAST_ADDR)) begin
						sweep_q <= '0;
						state_q <= S_IDLE;
					end else begin
						sweep_q <= sweep_q + AW'(1);
					end
				end
				S_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						cmd_q <= tcm_pkg::cmd_t'(cmd);
						char_q <= char_code;
						dx_q <= move_dx;
						dy_q <= move_dy;
						idx_ok_q <= 32'(cell_index) < CELL_COUNT;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					cell_data_q <= (cmd_q == tcm_pkg::CMD_READ_CELL && idx_ok_q)
						? {attr_rdata, char_rdata} : 16'd0;
					case (cmd_q)
						tcm_pkg::CMD_PUT_CHAR: begin
							if (screen_full) begin
								done_q <= 1'b0;
								state_q <= S_CLEAR;
							end else begin
								write_col_q <= 7'(next_col);
								write_row_q <= 5'(next_row);
								done_q <= 1'b1;
								state_q <= S_IDLE;
							end
						end
						tcm_pkg::CMD_BACKSPACE: begin
							if (write_col_q != 7'd0) begin
								write_col_q <= write_col_q - 7'd1;
							end
							done_q <= 1'b1;
							state_q <= S_IDLE;
						end
						tcm_pkg::CMD_MOUSE_MOVE: begin
							ptr_col_q <= new_ptr_col;
							ptr_row_q <= new_ptr_row;
							if (ptr_moved) begin
								done_q <= 1'b0;
								state_q <= S_MOUSE_RD;
							end else begin
								done_q <= 1'b1;
								state_q <= S_IDLE;
							end
						end
						default: begin
							done_q <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_MOUSE_RD: begin
					done_q <= 1'b0;
					state_q <= S_MOUSE_WR;
				end
				S_MOUSE_WR: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_CLEAR: begin
					if (sweep_q == AW'(LAST_ADDR)) begin
						sweep_q <= '0;
						write_col_q <= 7'd0;
						write_row_q <= 5'd0;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						done_q <= 1'b0;
						sweep_q <= sweep_q + AW'(1);
					end
				end
				default: begin
					done_q <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign cell_data = cell_data_q;
	assign cursor_col = write_col_q;
	assign cursor_row = write_row_q;
	assign mouse_col = ptr_col_q;
	assign mouse_row = ptr_row_q;

endmodule

[rtl/core/tcm_checker.sv]
// Port-level checks on the console's command and result timing and cursor positions.
module tcm_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [6:0]        cursor_col,
	input logic [4:0]        cursor_row,
	input logic [6:0]        mouse_col,
	input logic [4:0]        mouse_row
);

	// An accepted transaction keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after an accepted transaction");

	// No result can appear in the cycle right after an accept.
	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result strobe one cycle after accept");

	// A result always closes a busy period.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without preceding work");

	// While idle and not accepting, the cursors hold.
	a_idle_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !start) |=> ($stable(cursor_col) && $stable(cursor_row)
			&& $stable(mouse_col) && $stable(mouse_row)))
		else $error("cursor moved without a transaction");

	// Both cursors are on the screen whenever done is high.
	a_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(cursor_col) < COLUMNS && 32'(cursor_row) < ROWS
			&& 32'(mouse_col) < COLUMNS && 32'(mouse_row) < ROWS))
		else $error("cursor off the screen");

endmodule

bind text_console_with_mouse_cursor tcm_checker #(
	.COLUMNS(COLUMNS),
	.ROWS(ROWS)
) u_tcm_checker (.*);
